/* sv/avt_pkg.sv */
// Package for the affine vector transform block.
// Holds operation codes, matrix layout constants and the job record
// passed from the front end through the queue to the back end.
package avt_pkg;

  localparam int unsigned MatElems  = 12;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned FracBits  = 16;

  localparam logic signed [31:0] Q16One = 32'sd65536;

  typedef enum logic [2:0] {
    OP_WRITE     = 3'd0,
    OP_POINT     = 3'd1,
    OP_DIRECTION = 3'd2,
    OP_INV_DIR   = 3'd3,
    OP_INV_POINT = 3'd4
  } op_e;

  typedef struct packed {
    logic [2:0][32:0] vec;    // operand vector, signed, 33 bits each
    logic [8:0][31:0] coef;   // row-major 3x3 coefficients, signed
    logic [2:0][31:0] trans;  // translation added after the multiply, signed
  } avt_job_t;

endpackage

/* sv/avt_front.sv */
// Front end: holds the matrix store, applies write transactions and turns
// transform transactions into a job record. Depends on avt_pkg.
module avt_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [2:0]        op_i,
  input  logic [3:0]        elem_index_i,
  input  logic [31:0]       elem_value_i,
  input  logic [2:0][31:0]  vec_i,
  output avt_pkg::avt_job_t job_o
);
  import avt_pkg::*;

  logic [MatElems-1:0][31:0] mat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int e = 0; e < MatElems; e++) begin
        mat_q[e] <= (e inside {0, 5, 10}) ? Q16One : '0;
      end
    end else if (accept_i && (op_i == OP_WRITE) && (elem_index_i < 4'(MatElems))) begin
      mat_q[elem_index_i] <= elem_value_i;
    end
  end

  always_comb begin
    job_o = '0;
    case (op_e'(op_i))
      OP_POINT, OP_DIRECTION: begin
        for (int i = 0; i < 3; i++) begin
          job_o.vec[i] = {vec_i[i][31], vec_i[i]};
          for (int k = 0; k < 3; k++) begin
            job_o.coef[3*i+k] = mat_q[4*i+k];
          end
          if (op_i == OP_POINT) begin
            job_o.trans[i] = mat_q[4*i+3];
          end
        end
      end
      OP_INV_DIR, OP_INV_POINT: begin
        for (int i = 0; i < 3; i++) begin
          if (op_i == OP_INV_POINT) begin
            job_o.vec[i] = 33'($signed({vec_i[i][31], vec_i[i]})
                               - $signed({mat_q[4*i+3][31], mat_q[4*i+3]}));
          end else begin
            job_o.vec[i] = {vec_i[i][31], vec_i[i]};
          end
          for (int k = 0; k < 3; k++) begin
            job_o.coef[3*i+k] = mat_q[4*k+i];
          end
        end
      end
      default: begin
        job_o = '0;
      end
    endcase
  end

endmodule

/* sv/avt_queue.sv */
// Short job queue between front end and back end.
// Depends on avt_pkg for the job record and depth.
module avt_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  avt_pkg::avt_job_t data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output avt_pkg::avt_job_t data_o
);
  import avt_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  avt_job_t            mem_q [QueueDepth];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     cnt_q;

  assign full_o  = (cnt_q == CntW'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

/* sv/avt_back.sv */
// Back end: multiply, sum, floor shift and saturate in three stages.
// Depends on avt_pkg for the job record.
module avt_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_vld_i,
  input  avt_pkg::avt_job_t job_i,
  output logic              job_pop_o,
  output logic              out_vld_o,
  input  logic              out_rdy_i,
  output logic [2:0][31:0]  out_vec_o,
  output logic              out_ovf_o
);
  import avt_pkg::*;

  logic                     adv;
  logic                     vld1_q, vld2_q, out_vld_q;
  logic [8:0][64:0]         prod_q;
  logic [2:0][31:0]         trans_q;
  logic [2:0][66:0]         sum_q;
  logic [2:0][31:0]         out_vec_q;
  logic                     out_ovf_q;
  logic [2:0][66:0]         sum_d;
  logic [2:0][31:0]         sat_d;
  logic [2:0]               ovf_d;
  logic signed [50:0]       shifted;

  assign adv       = !out_vld_q || out_rdy_i;
  assign job_pop_o = adv && job_vld_i;
  assign out_vld_o = out_vld_q;
  assign out_vec_o = out_vec_q;
  assign out_ovf_o = out_ovf_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum_d[i] = 67'($signed(prod_q[3*i])) + 67'($signed(prod_q[3*i+1]))
               + 67'($signed(prod_q[3*i+2]))
               + (67'($signed(trans_q[i])) <<< FracBits);
    end
  end

  always_comb begin
    shifted = '0;
    for (int i = 0; i < 3; i++) begin
      shifted = 51'($signed(sum_q[i]) >>> FracBits);
      if (shifted > 51'sd2147483647) begin
        sat_d[i] = 32'h7fff_ffff;
        ovf_d[i] = 1'b1;
      end else if (shifted < -51'sd2147483648) begin
        sat_d[i] = 32'h8000_0000;
        ovf_d[i] = 1'b1;
      end else begin
        sat_d[i] = shifted[31:0];
        ovf_d[i] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          prod_q[3*i+k] <= 65'($signed(job_i.vec[k])) * 65'($signed(job_i.coef[3*i+k]));
        end
      end
      trans_q   <= job_i.trans;
      sum_q     <= sum_d;
      out_vec_q <= sat_d;
      out_ovf_q <= |ovf_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q    <= 1'b0;
      vld2_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vld1_q    <= job_vld_i;
      vld2_q    <= vld1_q;
      out_vld_q <= vld2_q;
    end
  end

endmodule

/* sv/affine_vector_transform.sv */
// Affine vector transform, top level: 3x4 Q16.16 matrix, four transform modes.
// Instantiates avt_front, avt_queue and avt_back; depends on avt_pkg.
//
// Input stream s_axis: tuser carries the operation (write element, point,
// direction, inverse direction, inverse point). tdata carries, from bit 0 up,
// element_index, element_value, in_x, in_y, in_z, zero padded to 136 bits.
// Write transactions update one matrix element as they are accepted; every
// later transaction sees the new value.
// Output stream m_axis: one transaction per input transaction, in order.
// tdata holds out_x, out_y, out_z; tuser holds the overflow flag. Writes and
// undefined operations return all zeros.
// From input to output a transaction passes the queue register, multiply
// stage, sum stage and saturate/output register.
// Throughput: one transaction per cycle while m_axis is not stalled; the nine
// 33x32 multipliers work in parallel, so each cycle can start a new vector.
// A stall on m_axis freezes the back pipeline; the two-entry queue absorbs
// accepted transactions and s_axis_tready drops when it is full.
// Reset sets the matrix to identity and empties queue and pipeline.
module affine_vector_transform (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [135:0]  s_axis_tdata,  // element_index, element_value, in_x, in_y, in_z
  input  logic [2:0]    s_axis_tuser,  // operation
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [95:0]   m_axis_tdata,  // out_x, out_y, out_z
  output logic [0:0]    m_axis_tuser   // overflow
);
  import avt_pkg::*;

  logic             accept;
  logic             q_full, q_empty, q_pop;
  avt_job_t         job_in, job_out;
  logic [2:0][31:0] vec_in, vec_out;
  logic             ovf;

  assign s_axis_tready = !q_full;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign vec_in        = s_axis_tdata[131:36];

  avt_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .op_i         (s_axis_tuser),
    .elem_index_i (s_axis_tdata[3:0]),
    .elem_value_i (s_axis_tdata[35:4]),
    .vec_i        (vec_in),
    .job_o        (job_in)
  );

  avt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .data_i  (job_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (job_out)
  );

  avt_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .job_vld_i (!q_empty),
    .job_i     (job_out),
    .job_pop_o (q_pop),
    .out_vld_o (m_axis_tvalid),
    .out_rdy_i (m_axis_tready),
    .out_vec_o (vec_out),
    .out_ovf_o (ovf)
  );

  assign m_axis_tdata = vec_out;
  assign m_axis_tuser = ovf;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !q_empty)
    else $error("queue empty after accepted transaction");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |->
      (m_axis_tdata[31:0]  == 32'h7fff_ffff || m_axis_tdata[31:0]  == 32'h8000_0000 ||
       m_axis_tdata[63:32] == 32'h7fff_ffff || m_axis_tdata[63:32] == 32'h8000_0000 ||
       m_axis_tdata[95:64] == 32'h7fff_ffff || m_axis_tdata[95:64] == 32'h8000_0000))
    else $error("overflow flagged without a saturated coordinate");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("pop from empty queue");

endmodule
